[hw/rtl/tile_frustum_plane_generator_assert.svh]
// assertion macros shared by the tile frustum plane generator rtl
`ifndef TILE_FRUSTUM_PLANE_GENERATOR_ASSERT_SVH
`define TILE_FRUSTUM_PLANE_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TFPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TFPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tfpg_pkg.sv]
// types, codes and helpers for the tile frustum plane generator
package tfpg_pkg;

  localparam int MaxTiles = 256;

  typedef enum logic [3:0] {
    RegTilesAcross = 4'd0,
    RegTilesDown   = 4'd1,
    RegRowOneXy    = 4'd2,
    RegRowOneZw    = 4'd3,
    RegRowTwoXy    = 4'd4,
    RegRowTwoZw    = 4'd5,
    RegRowFourXy   = 4'd6,
    RegRowFourZw   = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PlaneLeft   = 2'd0,
    PlaneRight  = 2'd1,
    PlaneBottom = 2'd2,
    PlaneTop    = 2'd3
  } plane_e;

  typedef struct packed {
    logic [15:0] idx;
    logic [1:0]  sel;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [3:0][31:0] p;
  } ptag_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // zero acts as one, anything beyond the grid limit acts as the limit
  function automatic logic [8:0] clamp_count(input logic [8:0] c);
    logic [8:0] r;
    if (c == 9'd0) begin
      r = 9'd1;
    end else if (int'(c) > MaxTiles) begin
      r = 9'(MaxTiles);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

[hw/rtl/tfpg_pipe_div.sv]
// pipelined restoring divider, one quotient bit per stage, with a tag alongside
module tfpg_pipe_div #(
  parameter int NW = 36,
  parameter int DW = 10,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic          v_q   [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_s;
    logic [DW-1:0] rem_s;
    logic [NW-1:0] num_s;
    logic [NW-1:0] quo_s;
    logic [DW-1:0] den_s;
    logic [TW-1:0] tag_s;
    logic [DW:0]   trial;

    if (k == 0) begin : g_first
      assign v_s   = valid_i;
      assign rem_s = '0;
      assign num_s = num_i;
      assign quo_s = '0;
      assign den_s = den_i;
      assign tag_s = tag_i;
    end else begin : g_next
      assign v_s   = v_q[k-1];
      assign rem_s = rem_q[k-1];
      assign num_s = num_q[k-1];
      assign quo_s = quo_q[k-1];
      assign den_s = den_q[k-1];
      assign tag_s = tag_q[k-1];
    end

    assign trial = {rem_s, num_s[NW-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= {1'b0, den_s}) begin
          rem_q[k] <= DW'(trial - {1'b0, den_s});
          quo_q[k] <= {quo_s[NW-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[DW-1:0];
          quo_q[k] <= {quo_s[NW-2:0], 1'b0};
        end
        num_q[k] <= num_s << 1;
        den_q[k] <= den_s;
        tag_q[k] <= tag_s;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign tag_o   = tag_q[NW-1];

endmodule

[hw/rtl/tile_frustum_plane_generator.sv]
// Tile frustum plane generator: takes one tile coordinate and returns its left, right,
// bottom and top planes as four result words in that order, one word per cycle while the
// result side does not stall; a new tile is held until all four planes of the previous
// tile have issued. Each plane passes through a pipelined bound divider, five
// arithmetic stages, a 32-stage square root and a pipelined normalising divider.
// A new tile is taken while earlier planes are still in flight or waiting at the output.
// Configuration must only be written with the block idle.
`include "tile_frustum_plane_generator_assert.svh"

module tile_frustum_plane_generator #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         tile_col_i,
  input  logic [7:0]         tile_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        tile_index_o,
  output logic [1:0]         plane_select_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o,
  output logic signed [31:0] plane_offset_o,
  output logic               degenerate_o,
  output logic               last_o
);

  import tfpg_pkg::*;

  localparam int BNW = FRAC_BITS + 12;
  localparam int ONW = FRAC_BITS + 33;
  localparam int SqrtSteps = 32;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] One  = 64'sd1 <<< FRAC_BITS;

  // configuration registers
  logic [8:0]  across_q, down_q;
  logic [63:0] r1_xy_q, r1_zw_q, r2_xy_q, r2_zw_q, r4_xy_q, r4_zw_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= 9'd1;
      down_q   <= 9'd1;
      r1_xy_q  <= '0;
      r1_zw_q  <= '0;
      r2_xy_q  <= '0;
      r2_zw_q  <= '0;
      r4_xy_q  <= '0;
      r4_zw_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTilesAcross: across_q <= cfg_data_i[8:0];
        RegTilesDown:   down_q   <= cfg_data_i[8:0];
        RegRowOneXy:    r1_xy_q  <= cfg_data_i;
        RegRowOneZw:    r1_zw_q  <= cfg_data_i;
        RegRowTwoXy:    r2_xy_q  <= cfg_data_i;
        RegRowTwoZw:    r2_zw_q  <= cfg_data_i;
        RegRowFourXy:   r4_xy_q  <= cfg_data_i;
        RegRowFourZw:   r4_zw_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [8:0] across, down;
  logic signed [31:0] r1 [4];
  logic signed [31:0] r2 [4];
  logic signed [31:0] r4 [4];

  assign across = clamp_count(across_q);
  assign down   = clamp_count(down_q);
  assign r1[0] = r1_xy_q[31:0];
  assign r1[1] = r1_xy_q[63:32];
  assign r1[2] = r1_zw_q[31:0];
  assign r1[3] = r1_zw_q[63:32];
  assign r2[0] = r2_xy_q[31:0];
  assign r2[1] = r2_xy_q[63:32];
  assign r2[2] = r2_zw_q[31:0];
  assign r2[3] = r2_zw_q[63:32];
  assign r4[0] = r4_xy_q[31:0];
  assign r4[1] = r4_xy_q[63:32];
  assign r4[2] = r4_zw_q[31:0];
  assign r4[3] = r4_zw_q[63:32];

  // whole pipeline moves whenever the output register can take a word
  logic adv;
  logic out_v_q;
  assign adv = !out_v_q || out_ready_i;

  // plane sequencer: holds one tile and issues its four planes
  logic        seq_v_q;
  logic [1:0]  seq_cnt_q;
  logic [7:0]  seq_col_q, seq_row_q;
  logic [15:0] seq_idx_q;
  logic        in_acc;
  logic [16:0] idx_full;

  assign in_ready_o = !seq_v_q || (adv && seq_cnt_q == PlaneTop);
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_full   = 17'(tile_row_i) * 17'(across) + 17'(tile_col_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_v_q   <= 1'b0;
      seq_cnt_q <= PlaneLeft;
    end else if (in_acc) begin
      seq_v_q   <= 1'b1;
      seq_cnt_q <= PlaneLeft;
    end else if (seq_v_q && adv) begin
      if (seq_cnt_q == PlaneTop) begin
        seq_v_q <= 1'b0;
      end
      seq_cnt_q <= seq_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_col_q <= tile_col_i;
      seq_row_q <= tile_row_i;
      seq_idx_q <= idx_full[15:0];
    end
  end

  // bound = round(2*i/count * 2^F) - 2^F, numerator kept non-negative
  logic [8:0]     bnd_i, bnd_cnt;
  logic [BNW-1:0] bnd_num;
  logic [9:0]     bnd_den;
  meta_t          bnd_meta;

  assign bnd_i    = (seq_cnt_q[1] ? {1'b0, seq_row_q} : {1'b0, seq_col_q}) + {8'd0, seq_cnt_q[0]};
  assign bnd_cnt  = seq_cnt_q[1] ? down : across;
  assign bnd_num  = (BNW'(bnd_i) << (FRAC_BITS + 2)) + BNW'(bnd_cnt);
  assign bnd_den  = {bnd_cnt, 1'b0};
  assign bnd_meta = '{idx: seq_idx_q, sel: seq_cnt_q};

  logic           bdiv_v;
  logic [BNW-1:0] bdiv_q;
  meta_t          bdiv_meta;

  tfpg_pipe_div #(
    .NW(BNW),
    .DW(10),
    .TW($bits(meta_t))
  ) u_bound_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (seq_v_q),
    .num_i   (bnd_num),
    .den_i   (bnd_den),
    .tag_i   (bnd_meta),
    .valid_o (bdiv_v),
    .quo_o   (bdiv_q),
    .tag_o   (bdiv_meta)
  );

  // stage b: bound
  logic               b_v_q;
  logic signed [31:0] b_bound_q;
  meta_t              b_meta_q;
  logic signed [63:0] bnd_wide;

  assign bnd_wide = $signed(64'(bdiv_q)) - One;

  // stage c: row four times bound
  logic               c_v_q;
  logic signed [63:0] c_prod_q [4];
  meta_t              c_meta_q;

  // stage d: plane components
  logic               d_v_q;
  ptag_t              d_q;
  logic signed [63:0] t_w    [4];
  logic signed [63:0] diff_w [4];
  logic signed [31:0] a_w    [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_w[k]    = c_meta_q.sel[1] ? r2[k] : r1[k];
      t_w[k]    = (c_prod_q[k] + Half) >>> FRAC_BITS;
      diff_w[k] = c_meta_q.sel[0] ? (t_w[k] - 64'(a_w[k])) : (64'(a_w[k]) - t_w[k]);
    end
  end

  // stage e: squares of xyz
  logic        e_v_q;
  ptag_t       e_q;
  logic [63:0] e_sq_q [3];
  logic [31:0] mag_e  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_e[k] = d_q.p[k][31] ? (~d_q.p[k] + 32'd1) : d_q.p[k];
    end
  end

  // stage f: sum of squares
  logic        f_v_q;
  ptag_t       f_q;
  logic [63:0] f_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else if (adv) begin
      b_v_q <= bdiv_v;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_bound_q <= sat32(bnd_wide);
      b_meta_q  <= bdiv_meta;
      for (int k = 0; k < 4; k++) begin
        c_prod_q[k] <= r4[k] * b_bound_q;
        d_q.p[k]    <= sat32(diff_w[k]);
      end
      c_meta_q  <= b_meta_q;
      d_q.meta  <= c_meta_q;
      for (int k = 0; k < 3; k++) begin
        e_sq_q[k] <= mag_e[k] * mag_e[k];
      end
      e_q     <= d_q;
      f_sum_q <= e_sq_q[0] + e_sq_q[1] + e_sq_q[2];
      f_q     <= e_q;
    end
  end

  // square root, one result bit per stage
  logic        g_v_q [SqrtSteps];
  logic [63:0] g_s_q [SqrtSteps];
  logic [63:0] g_r_q [SqrtSteps];
  ptag_t       g_t_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic        v_s;
    logic [63:0] s_s, r_s, trial;
    ptag_t       t_s;

    if (k == 0) begin : g_first
      assign v_s = f_v_q;
      assign s_s = f_sum_q;
      assign r_s = '0;
      assign t_s = f_q;
    end else begin : g_next
      assign v_s = g_v_q[k-1];
      assign s_s = g_s_q[k-1];
      assign r_s = g_r_q[k-1];
      assign t_s = g_t_q[k-1];
    end

    assign trial = r_s + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        g_v_q[k] <= 1'b0;
      end else if (adv) begin
        g_v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (s_s >= trial) begin
          g_s_q[k] <= s_s - trial;
          g_r_q[k] <= (r_s >> 1) + Bit;
        end else begin
          g_s_q[k] <= s_s;
          g_r_q[k] <= r_s >> 1;
        end
        g_t_q[k] <= t_s;
      end
    end
  end

  // normalise: round(|c| * 2^F / L) with ties away from zero, sign restored after
  logic [31:0]    len;
  logic           deg;
  ptag_t          sq_t;
  logic           neg_w [4];
  logic [31:0]    mag_w [4];
  logic [ONW-1:0] num_w [4];

  assign len  = g_r_q[SqrtSteps-1][31:0];
  assign deg  = (len == 32'd0);
  assign sq_t = g_t_q[SqrtSteps-1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg_w[k] = sq_t.p[k][31];
      mag_w[k] = neg_w[k] ? (~sq_t.p[k] + 32'd1) : sq_t.p[k];
      num_w[k] = (ONW'(mag_w[k]) << FRAC_BITS) + ONW'(len[31:1]);
    end
  end

  logic           ndiv_v;
  logic [ONW-1:0] ndiv_q [4];
  logic           ndiv_neg [4];
  meta_t          ndiv_meta;
  logic           ndiv_deg;

  tfpg_pipe_div #(
    .NW(ONW),
    .DW(32),
    .TW($bits(meta_t) + 2)
  ) u_norm_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_v_q[SqrtSteps-1]),
    .num_i   (num_w[0]),
    .den_i   (len),
    .tag_i   ({deg, sq_t.meta, neg_w[0]}),
    .valid_o (ndiv_v),
    .quo_o   (ndiv_q[0]),
    .tag_o   ({ndiv_deg, ndiv_meta, ndiv_neg[0]})
  );

  for (genvar k = 1; k < 4; k++) begin : g_norm
    tfpg_pipe_div #(
      .NW(ONW),
      .DW(32),
      .TW(1)
    ) u_norm_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (g_v_q[SqrtSteps-1]),
      .num_i   (num_w[k]),
      .den_i   (len),
      .tag_i   (neg_w[k]),
      .valid_o (),
      .quo_o   (ndiv_q[k]),
      .tag_o   (ndiv_neg[k])
    );
  end

  logic signed [63:0] res_wide [4];
  logic signed [31:0] res_w    [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      res_wide[k] = ndiv_neg[k] ? -$signed(64'(ndiv_q[k])) : $signed(64'(ndiv_q[k]));
      res_w[k]    = ndiv_deg ? 32'sd0 : sat32(res_wide[k]);
    end
  end

  // output register
  logic [15:0]        out_idx_q;
  logic [1:0]         out_sel_q;
  logic signed [31:0] out_c_q [4];
  logic               out_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= ndiv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q <= ndiv_meta.idx;
      out_sel_q <= ndiv_meta.sel;
      out_deg_q <= ndiv_deg;
      for (int k = 0; k < 4; k++) begin
        out_c_q[k] <= res_w[k];
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign tile_index_o   = out_idx_q;
  assign plane_select_o = out_sel_q;
  assign normal_x_o     = out_c_q[0];
  assign normal_y_o     = out_c_q[1];
  assign normal_z_o     = out_c_q[2];
  assign plane_offset_o = out_c_q[3];
  assign degenerate_o   = out_deg_q;
  assign last_o         = (out_sel_q == PlaneTop);

  `TFPG_ASSERT_NXT(a_seq_hold, seq_v_q && !adv, seq_v_q && $stable(seq_cnt_q), "sequencer moved while stalled")
  `TFPG_ASSERT_IMP(a_no_mid_tile, in_acc && seq_v_q, adv && seq_cnt_q == PlaneTop, "tile taken mid sequence")
  `TFPG_ASSERT_NXT(a_start_left, in_acc, seq_v_q && seq_cnt_q == PlaneLeft, "new tile not started at left plane")
  `TFPG_ASSERT_IMP(a_deg_zero, out_v_q && out_deg_q, out_c_q[0] == 0 && out_c_q[3] == 0, "degenerate plane not zeroed")

endmodule
